@@ src/svwm_pkg.sv @@
// Shared types, constants and the microcode table of the shell mean unit.
// No dependencies; every other file of the block takes its names from here.
`timescale 1ns / 1ps
`default_nettype none

package svwm_pkg;

	// Field and datapath widths
	localparam int DATA_W         = 32;
	localparam int DENS_FRAC_BITS = 16;
	localparam int OPA_W          = 36;
	localparam int OPB_W          = 32;
	localparam int PROD_W         = OPA_W + OPB_W;
	localparam int ACC_W          = 64;
	localparam int SUM_W          = ACC_W + 1;

	// Fixed-point shifts
	localparam int Q30_SH    = 30;
	localparam int PHI_SH    = 29;
	localparam int RECIP3_SH = 33;

	// floor(2^33 / 3): q0 = (x * RECIP3) >> 33 lands at most two below x / 3
	localparam logic [OPB_W-1:0] RECIP3    = 32'hAAAA_AAAA;
	localparam logic [DATA_W-1:0] CLAMP_MAX = 32'h8000_0000;

	// Long division of the shell sums yields one mean bit per step
	localparam int DIV_ITERS = DATA_W;
	localparam int CNT_W     = $clog2(DIV_ITERS);

	// One input beat and one result beat
	typedef struct packed {
		logic [DATA_W-1:0] density;
		logic [DATA_W-1:0] theta_weight;
		logic [DATA_W-1:0] phi_weight;
		logic [DATA_W-1:0] outer_radius;
		logic [DATA_W-1:0] inner_radius;
		logic              last_in_shell;
	} cell_t;

	typedef struct packed {
		logic [DATA_W-1:0] mean_density;
		logic              zero_volume;
		logic              saturated;
	} mean_t;

	// Microcode fields
	typedef enum logic [1:0] {A_RO, A_RI, A_X, A_Y} mul_a_t;

	typedef enum logic [2:0] {B_RO, B_RI, B_RECIP3, B_TW, B_PW, B_DENS} mul_b_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_X_P30,
		OP_Y_P30,
		OP_Y_P33,
		OP_X_P29,
		OP_X_SUB,
		OP_X_DIV3FIX,
		OP_ACC_VOL,
		OP_ACC_WT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [1:0] {JMP_NONE, JMP_END_IF_NOT_LAST, JMP_LOOP, JMP_END} jmp_t;

	typedef struct packed {
		logic   mul_en;
		mul_a_t a_sel;
		mul_b_t b_sel;
		dp_op_t op;
		jmp_t   jmp;
		logic   cnt_load;
	} uword_t;

	// Status from datapath to sequencer
	typedef struct packed {
		logic last;
		logic out_hold;
	} stat_t;

	// Program steps
	typedef enum logic [4:0] {
		ST_SQ_OUTER,
		ST_SQ_INNER,
		ST_CUBE_OUTER,
		ST_CUBE_INNER,
		ST_TAKE_CI,
		ST_DIFF,
		ST_MUL_RECIP,
		ST_TAKE_Q0,
		ST_FIX_Q,
		ST_MUL_THETA,
		ST_TAKE_V1,
		ST_MUL_PHI,
		ST_TAKE_VOL,
		ST_MUL_DENS,
		ST_ACC_WT,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_EMIT
	} step_t;

	localparam uword_t UWORD_IDLE = '{
		mul_en:   1'b0,
		a_sel:    A_RO,
		b_sel:    B_RO,
		op:       OP_NOP,
		jmp:      JMP_NONE,
		cnt_load: 1'b0
	};

	// Control store: one word per step
	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		w = UWORD_IDLE;
		case (pc)
			ST_SQ_OUTER: begin
				w.mul_en = 1'b1; w.a_sel = A_RO; w.b_sel = B_RO;
			end
			ST_SQ_INNER: begin
				w.mul_en = 1'b1; w.a_sel = A_RI; w.b_sel = B_RI;
				w.op = OP_X_P30;
			end
			ST_CUBE_OUTER: begin
				w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_RO;
				w.op = OP_Y_P30;
			end
			ST_CUBE_INNER: begin
				w.mul_en = 1'b1; w.a_sel = A_Y; w.b_sel = B_RI;
				w.op = OP_X_P30;
			end
			ST_TAKE_CI:   w.op = OP_Y_P30;
			ST_DIFF:      w.op = OP_X_SUB;
			ST_MUL_RECIP: begin
				w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_RECIP3;
			end
			ST_TAKE_Q0:   w.op = OP_Y_P33;
			ST_FIX_Q:     w.op = OP_X_DIV3FIX;
			ST_MUL_THETA: begin
				w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_TW;
			end
			ST_TAKE_V1:   w.op = OP_X_P30;
			ST_MUL_PHI: begin
				w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_PW;
			end
			ST_TAKE_VOL:  w.op = OP_X_P29;
			ST_MUL_DENS: begin
				w.mul_en = 1'b1; w.a_sel = A_X; w.b_sel = B_DENS;
				w.op = OP_ACC_VOL;
			end
			ST_ACC_WT: begin
				w.op = OP_ACC_WT; w.jmp = JMP_END_IF_NOT_LAST;
			end
			ST_DIV_INIT: begin
				w.op = OP_DIV_INIT; w.cnt_load = 1'b1;
			end
			ST_DIV_STEP: begin
				w.op = OP_DIV_STEP; w.jmp = JMP_LOOP;
			end
			ST_EMIT: begin
				w.op = OP_EMIT; w.jmp = JMP_END;
			end
			default: w.jmp = JMP_END;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/svwm_in_if.sv @@
// Cell channel of the shell mean unit: valid, ready and one cell per beat.
// Depends on svwm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface svwm_in_if;
	logic                          valid;
	logic                          ready;
	logic [svwm_pkg::DATA_W-1:0]   density;
	logic [svwm_pkg::DATA_W-1:0]   theta_weight;
	logic [svwm_pkg::DATA_W-1:0]   phi_weight;
	logic [svwm_pkg::DATA_W-1:0]   outer_radius;
	logic [svwm_pkg::DATA_W-1:0]   inner_radius;
	logic                          last_in_shell;

	modport source (
		output valid, density, theta_weight, phi_weight, outer_radius, inner_radius,
		output last_in_shell,
		input  ready
	);
	modport sink (
		input  valid, density, theta_weight, phi_weight, outer_radius, inner_radius,
		input  last_in_shell,
		output ready
	);
endinterface

`default_nettype wire

@@ src/svwm_out_if.sv @@
// Result channel of the shell mean unit: valid, ready and one shell mean per beat.
// Depends on svwm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface svwm_out_if;
	logic                        valid;
	logic                        ready;
	logic [svwm_pkg::DATA_W-1:0] mean_density;
	logic                        zero_volume;
	logic                        saturated;

	modport source (
		output valid, mean_density, zero_volume, saturated,
		input  ready
	);
	modport sink (
		input  valid, mean_density, zero_volume, saturated,
		output ready
	);
endinterface

`default_nettype wire

@@ src/svwm_seq.sv @@
// Microcode sequencer: step counter, loop counter and control store lookup.
// Depends on svwm_pkg (step_t, uword_t, ucode table, stat_t).
`timescale 1ns / 1ps
`default_nettype none

module svwm_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire svwm_pkg::stat_t   stat,
	output logic                   ready,
	output svwm_pkg::uword_t       ctrl
);

	logic                       busy_q, busy_d;
	svwm_pkg::step_t            pc_q, pc_d;
	logic [svwm_pkg::CNT_W-1:0] cnt_q, cnt_d;
	svwm_pkg::uword_t           word;
	logic                       hold;
	logic                       exec;

	// Fetch; the emit step waits while the result register is full and not being read
	always_comb begin
		word = svwm_pkg::ucode(pc_q);
		hold = (word.op == svwm_pkg::OP_EMIT) && stat.out_hold;
		exec = busy_q && !hold;
	end

	// Outputs
	always_comb begin
		ready = !busy_q;
		ctrl  = exec ? word : svwm_pkg::UWORD_IDLE;
	end

	// Next step
	always_comb begin
		busy_d = busy_q;
		pc_d   = pc_q;
		cnt_d  = cnt_q;
		if (start) begin
			busy_d = 1'b1;
			pc_d   = svwm_pkg::ST_SQ_OUTER;
		end else if (exec) begin
			if (word.cnt_load) begin
				cnt_d = svwm_pkg::CNT_W'(svwm_pkg::DIV_ITERS - 1);
			end
			case (word.jmp)
				svwm_pkg::JMP_NONE: begin
					pc_d = svwm_pkg::step_t'(pc_q + 1'b1);
				end
				svwm_pkg::JMP_END_IF_NOT_LAST: begin
					if (!stat.last) begin
						busy_d = 1'b0;
					end else begin
						pc_d = svwm_pkg::step_t'(pc_q + 1'b1);
					end
				end
				svwm_pkg::JMP_LOOP: begin
					if (cnt_q != '0) begin
						cnt_d = cnt_q - 1'b1;
					end else begin
						pc_d = svwm_pkg::step_t'(pc_q + 1'b1);
					end
				end
				svwm_pkg::JMP_END: begin
					busy_d = 1'b0;
				end
				default: busy_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= svwm_pkg::ST_SQ_OUTER;
			cnt_q  <= '0;
		end else begin
			busy_q <= busy_d;
			pc_q   <= pc_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

`default_nettype wire

@@ src/svwm_dp.sv @@
// Datapath: cell registers, shared multiplier, scratch registers, saturating
// shell sums, bit-serial divider and the result register. Depends on svwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svwm_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               accept,
	input  wire svwm_pkg::cell_t    cell_in,
	input  wire svwm_pkg::uword_t   ctrl,
	input  wire logic               res_ready,
	output logic                    res_valid,
	output svwm_pkg::mean_t         res,
	output svwm_pkg::stat_t         stat
);

	localparam int DW = svwm_pkg::DATA_W;
	localparam int AW = svwm_pkg::OPA_W;
	localparam int PW = svwm_pkg::PROD_W;
	localparam int SW = svwm_pkg::ACC_W;
	localparam int F  = svwm_pkg::DENS_FRAC_BITS;

	function automatic logic [DW-1:0] clamp_q30(input logic [DW-1:0] v);
		return (v > svwm_pkg::CLAMP_MAX) ? svwm_pkg::CLAMP_MAX : v;
	endfunction

	// Cell operands
	logic [DW-1:0] dens_q, tw_q, pw_q, ro_q, ri_q;
	logic          last_q;

	// Multiplier and scratch
	logic [AW-1:0]               opa;
	logic [svwm_pkg::OPB_W-1:0]  opb;
	logic [PW-1:0]               prod_d, prod_q;
	logic [AW-1:0]               x_q, x_d, y_q, y_d;
	logic [3:0]                  r3;
	logic [1:0]                  adj;

	// Shell sums
	logic [SW-1:0]               wsum_q, wsum_d, vsum_q, vsum_d;
	logic                        ovf_q, ovf_d;
	logic [svwm_pkg::SUM_W-1:0]  vsum_add, wsum_add;

	// Divider
	logic [SW-1:0]               rem_q, rem_d, rem_init;
	logic [DW-1:0]               quo_q, quo_d;
	logic                        big_q, big_d, zero_q, zero_d;
	logic [svwm_pkg::SUM_W-1:0]  trial, trial_sub;
	logic                        ge;

	// Result register
	logic                        out_valid_q;
	logic [DW-1:0]               mean_q;
	logic                        zero_vol_q, sat_q;
	logic                        emit;

	// Latch the cell; radii and theta weight are clamped to 2.0
	always_ff @(posedge clk) begin
		if (accept) begin
			dens_q <= cell_in.density;
			tw_q   <= clamp_q30(cell_in.theta_weight);
			pw_q   <= cell_in.phi_weight;
			ro_q   <= clamp_q30(cell_in.outer_radius);
			ri_q   <= clamp_q30(cell_in.inner_radius);
			last_q <= cell_in.last_in_shell;
		end
	end

	// Shared multiplier
	always_comb begin
		case (ctrl.a_sel)
			svwm_pkg::A_RO: opa = AW'(ro_q);
			svwm_pkg::A_RI: opa = AW'(ri_q);
			svwm_pkg::A_X:  opa = x_q;
			svwm_pkg::A_Y:  opa = y_q;
			default:        opa = '0;
		endcase
		case (ctrl.b_sel)
			svwm_pkg::B_RO:     opb = ro_q;
			svwm_pkg::B_RI:     opb = ri_q;
			svwm_pkg::B_RECIP3: opb = svwm_pkg::RECIP3;
			svwm_pkg::B_TW:     opb = tw_q;
			svwm_pkg::B_PW:     opb = pw_q;
			svwm_pkg::B_DENS:   opb = dens_q;
			default:            opb = '0;
		endcase
		prod_d = PW'(opa) * PW'(opb);
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_q <= prod_d;
		end
	end

	// Divide-by-3 fix-up: remainder of diff - 3*q0 is below 9
	always_comb begin
		r3  = x_q[3:0] - y_q[3:0] - {y_q[2:0], 1'b0};
		adj = (r3 >= 4'd6) ? 2'd2 : ((r3 >= 4'd3) ? 2'd1 : 2'd0);
	end

	// Adders, compares and the divider step
	always_comb begin
		vsum_add  = {1'b0, vsum_q} + svwm_pkg::SUM_W'(x_q);
		wsum_add  = {1'b0, wsum_q} + svwm_pkg::SUM_W'(prod_q >> F);
		rem_init  = SW'(wsum_q >> (DW - F));
		trial     = {rem_q, quo_q[DW-1]};
		ge        = trial >= {1'b0, vsum_q};
		trial_sub = trial - {1'b0, vsum_q};
	end

	// Operation of the current step
	always_comb begin
		x_d    = x_q;
		y_d    = y_q;
		wsum_d = wsum_q;
		vsum_d = vsum_q;
		ovf_d  = ovf_q;
		rem_d  = rem_q;
		quo_d  = quo_q;
		big_d  = big_q;
		zero_d = zero_q;
		emit   = 1'b0;
		case (ctrl.op)
			svwm_pkg::OP_NOP:       ;
			svwm_pkg::OP_X_P30:     x_d = AW'(prod_q >> svwm_pkg::Q30_SH);
			svwm_pkg::OP_Y_P30:     y_d = AW'(prod_q >> svwm_pkg::Q30_SH);
			svwm_pkg::OP_Y_P33:     y_d = AW'(prod_q >> svwm_pkg::RECIP3_SH);
			svwm_pkg::OP_X_P29:     x_d = AW'(prod_q >> svwm_pkg::PHI_SH);
			svwm_pkg::OP_X_SUB:     x_d = (x_q > y_q) ? (x_q - y_q) : '0;
			svwm_pkg::OP_X_DIV3FIX: x_d = y_q + AW'(adj);
			svwm_pkg::OP_ACC_VOL: begin
				if (vsum_add[SW]) begin
					vsum_d = '1;
					ovf_d  = 1'b1;
				end else begin
					vsum_d = vsum_add[SW-1:0];
				end
			end
			svwm_pkg::OP_ACC_WT: begin
				if (wsum_add[SW]) begin
					wsum_d = '1;
					ovf_d  = 1'b1;
				end else begin
					wsum_d = wsum_add[SW-1:0];
				end
			end
			svwm_pkg::OP_DIV_INIT: begin
				rem_d  = rem_init;
				quo_d  = DW'(wsum_q << F);
				big_d  = rem_init >= vsum_q;
				zero_d = vsum_q == '0;
			end
			svwm_pkg::OP_DIV_STEP: begin
				rem_d = ge ? trial_sub[SW-1:0] : trial[SW-1:0];
				quo_d = {quo_q[DW-2:0], ge};
			end
			svwm_pkg::OP_EMIT: begin
				emit   = 1'b1;
				wsum_d = '0;
				vsum_d = '0;
				ovf_d  = 1'b0;
			end
			default: ;
		endcase
	end

	// Scratch and divider registers
	always_ff @(posedge clk) begin
		x_q    <= x_d;
		y_q    <= y_d;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		big_q  <= big_d;
		zero_q <= zero_d;
	end

	// Shell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			vsum_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			wsum_q <= wsum_d;
			vsum_q <= vsum_d;
			ovf_q  <= ovf_d;
		end
	end

	// Result register and its beat handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mean_q     <= zero_q ? '0 : (big_q ? '1 : quo_q);
			zero_vol_q <= zero_q;
			sat_q      <= ovf_q;
		end
	end

	always_comb begin
		res_valid         = out_valid_q;
		res.mean_density  = mean_q;
		res.zero_volume   = zero_vol_q;
		res.saturated     = sat_q;
		stat.last         = last_q;
		stat.out_hold     = out_valid_q && !res_ready;
	end

endmodule

`default_nettype wire

@@ src/shell_volume_weighted_mean_unit.sv @@
// Shell mean unit: takes the cells of one radial shell and returns the
// volume-weighted mean density on the cell marked last_in_shell. A cell that
// is not last occupies the block from the beat that takes it through fifteen
// microcode steps that run the two cubes, the divide by three and the weight
// and density products through a single shared 36x32 multiplier. The last
// cell of a shell runs the same fifteen steps, then a bit-serial long
// division of the two 64-bit sums (one set-up step, 32 quotient steps) and
// one step to load the result register. Cells are taken one at a time; a
// finished mean waits in its own register, so the next shell's cells flow
// in while it is unread, and only the following result waits for it to go.
// Depends on svwm_pkg, svwm_in_if, svwm_out_if, svwm_seq and svwm_dp.
`timescale 1ns / 1ps
`default_nettype none

module shell_volume_weighted_mean_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	svwm_in_if.sink     cells,
	svwm_out_if.source  means
);

	logic             accept;
	logic             seq_ready;
	svwm_pkg::cell_t  cell_in;
	svwm_pkg::uword_t ctrl;
	svwm_pkg::stat_t  stat;
	svwm_pkg::mean_t  res;
	logic             res_valid;

	// Input beat
	always_comb begin
		accept                = cells.valid && cells.ready;
		cell_in.density       = cells.density;
		cell_in.theta_weight  = cells.theta_weight;
		cell_in.phi_weight    = cells.phi_weight;
		cell_in.outer_radius  = cells.outer_radius;
		cell_in.inner_radius  = cells.inner_radius;
		cell_in.last_in_shell = cells.last_in_shell;
	end

	assign cells.ready = seq_ready;

	svwm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.stat   (stat),
		.ready  (seq_ready),
		.ctrl   (ctrl)
	);

	svwm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.cell_in   (cell_in),
		.ctrl      (ctrl),
		.res_ready (means.ready),
		.res_valid (res_valid),
		.res       (res),
		.stat      (stat)
	);

	// Result beat
	assign means.valid        = res_valid;
	assign means.mean_density = res.mean_density;
	assign means.zero_volume  = res.zero_volume;
	assign means.saturated    = res.saturated;

	// A zero-volume shell always reports a zero mean
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		means.valid && means.zero_volume |-> means.mean_density == '0)
		else $error("zero-volume shell with nonzero mean");

	// A cell that does not close its shell never produces a result next cycle
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid && cells.ready && !cells.last_in_shell |=> !$rose(means.valid))
		else $error("result raised right after a non-final cell");

	// The sequencer is busy right after taking a cell
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cells.valid && cells.ready |=> !cells.ready)
		else $error("second cell taken while the first is in work");

	// Results only come out of the emit step, never while the sequencer is idle
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(means.valid) |-> $past(!seq_ready))
		else $error("result appeared with the sequencer idle");

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking bench for shell_volume_weighted_mean_unit: drives cells of
// radial shells and checks every shell mean against an in-bench prediction.
// Depends on svwm_pkg, svwm_in_if, svwm_out_if and the unit itself.
`timescale 1ns / 1ps
`default_nettype none

import svwm_pkg::*;

// Tracks the running shell sums and holds the means still owed by the unit
class shell_mean_tracker;
	logic [ACC_W-1:0] dens_vol_sum = '0;
	logic [ACC_W-1:0] vol_sum = '0;
	bit               sum_clipped;
	mean_t            owed_means[$];
	int               mismatches;
	int               means_seen;

	function logic [63:0] clamp_q30(input logic [DATA_W-1:0] v);
		return (v > CLAMP_MAX) ? 64'(CLAMP_MAX) : 64'(v);
	endfunction

	// r^3 in Q.30, truncating after each product
	function logic [63:0] cube_q30(input logic [63:0] r);
		logic [63:0] sq;
		sq = (r * r) >> Q30_SH;
		return (sq * r) >> Q30_SH;
	endfunction

	// Add that sticks at all ones on carry out
	function logic [ACC_W-1:0] clip_add(input logic [ACC_W-1:0] acc,
			input logic [ACC_W-1:0] term);
		logic [ACC_W:0] s;
		s = {1'b0, acc} + {1'b0, term};
		if (s[ACC_W]) begin
			sum_clipped = 1'b1;
			return '1;
		end
		return s[ACC_W-1:0];
	endfunction

	// One accepted cell: update the sums, and on the last cell owe a mean
	function void take_cell(input cell_t c);
		logic [63:0]  tw, ro, ri, co, ci, radial, v1, vol, wt;
		logic [127:0] wide;
		mean_t        m;
		tw = clamp_q30(c.theta_weight);
		ro = clamp_q30(c.outer_radius);
		ri = clamp_q30(c.inner_radius);
		co = cube_q30(ro);
		ci = cube_q30(ri);
		radial = (co > ci) ? (co - ci) / 64'd3 : 64'd0;
		v1 = (radial * tw) >> Q30_SH;
		wide = {64'd0, v1} * {96'd0, c.phi_weight};
		vol = wide[PHI_SH +: 64];
		wide = {64'd0, vol} * {96'd0, c.density};
		wt = wide[DENS_FRAC_BITS +: 64];
		dens_vol_sum = clip_add(dens_vol_sum, wt);
		vol_sum = clip_add(vol_sum, vol);
		if (!c.last_in_shell)
			return;
		m.saturated = sum_clipped;
		if (vol_sum == '0) begin
			m.mean_density = '0;
			m.zero_volume = 1'b1;
		end else begin
			wide = ({64'd0, dens_vol_sum} << DENS_FRAC_BITS) / {64'd0, vol_sum};
			m.mean_density = (wide >> DATA_W) != '0 ? '1 : wide[DATA_W-1:0];
			m.zero_volume = 1'b0;
		end
		owed_means.push_back(m);
		dens_vol_sum = '0;
		vol_sum = '0;
		sum_clipped = 1'b0;
	endfunction

	task report_mismatch(input string what);
		if (mismatches < 100)
			$display("mismatch at mean %0d: %s", means_seen, what);
		mismatches++;
	endtask

	// One accepted result beat against the oldest owed mean
	task check_mean(input mean_t got);
		mean_t want;
		means_seen++;
		if (owed_means.size() == 0) begin
			report_mismatch($sformatf("mean %h with no shell finished", got.mean_density));
			return;
		end
		want = owed_means.pop_front();
		if (got.mean_density !== want.mean_density)
			report_mismatch($sformatf("mean_density %h, want %h",
				got.mean_density, want.mean_density));
		if (got.zero_volume !== want.zero_volume)
			report_mismatch($sformatf("zero_volume %b, want %b",
				got.zero_volume, want.zero_volume));
		if (got.saturated !== want.saturated)
			report_mismatch($sformatf("saturated %b, want %b",
				got.saturated, want.saturated));
	endtask
endclass

module tb;

	localparam int RANDOM_CELLS    = 800;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int SETTLE_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT  = 20000;

	logic clk = 1'b0;
	logic arst_n;

	svwm_in_if  cells_if ();
	svwm_out_if means_if ();

	shell_mean_tracker shells = new;

	bit steady;
	bit hold_off_req;
	int burst_left;
	int idle_cycles;

	shell_volume_weighted_mean_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cells  (cells_if),
		.means  (means_if)
	);

	always #1 clk = ~clk;

	// Beat monitor and no-progress watchdog
	always @(posedge clk) begin
		cell_t seen_cell;
		mean_t seen_mean;
		if (arst_n === 1'b1) begin
			if (cells_if.valid && cells_if.ready) begin
				seen_cell.density = cells_if.density;
				seen_cell.theta_weight = cells_if.theta_weight;
				seen_cell.phi_weight = cells_if.phi_weight;
				seen_cell.outer_radius = cells_if.outer_radius;
				seen_cell.inner_radius = cells_if.inner_radius;
				seen_cell.last_in_shell = cells_if.last_in_shell;
				shells.take_cell(seen_cell);
			end
			if (means_if.valid && means_if.ready) begin
				seen_mean.mean_density = means_if.mean_density;
				seen_mean.zero_volume = means_if.zero_volume;
				seen_mean.saturated = means_if.saturated;
				shells.check_mean(seen_mean);
			end
		end
		if (arst_n !== 1'b1 || (cells_if.valid && cells_if.ready)
				|| (means_if.valid && means_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: stall pattern redrawn each time the slot counter wraps, plus one long hold-off
	initial begin
		logic [15:0] pattern;
		int unsigned slot;
		means_if.ready <= 1'b0;
		pattern = '1;
		slot = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				means_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			if (slot == 0) begin
				case ($urandom_range(0, 3))
					0: pattern = '1;
					1: pattern = 16'($urandom) | 16'h1;
					2: pattern = 16'($urandom & $urandom) | 16'h1;
					default: pattern = ~16'($urandom & $urandom);
				endcase
			end
			means_if.ready <= pattern[slot[3:0]];
			slot = (slot + 1) % 48;
		end
	end

	function automatic cell_t make_cell(input logic [DATA_W-1:0] dens, tw, pw, ro, ri,
			input logic last);
		cell_t c;
		c.density = dens;
		c.theta_weight = tw;
		c.phi_weight = pw;
		c.outer_radius = ro;
		c.inner_radius = ri;
		c.last_in_shell = last;
		return c;
	endfunction

	// Radius or theta weight: edges, tiny, in range, and above the 2.0 clamp
	function automatic logic [DATA_W-1:0] pick_q30();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return CLAMP_MAX;
			2: return $urandom;
			3: return $urandom_range(1, 64);
			default: return $urandom_range(0, CLAMP_MAX);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_density();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 32'h0001_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_phi();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// One beat on the cell channel; returns at the edge that takes it
	task automatic push_cell(input cell_t c);
		cells_if.valid <= 1'b1;
		cells_if.density <= c.density;
		cells_if.theta_weight <= c.theta_weight;
		cells_if.phi_weight <= c.phi_weight;
		cells_if.outer_radius <= c.outer_radius;
		cells_if.inner_radius <= c.inner_radius;
		cells_if.last_in_shell <= c.last_in_shell;
		@(posedge clk);
		while (!cells_if.ready) @(posedge clk);
	endtask

	// Sender runs in bursts with random gaps, unless held steady
	task automatic offer_cell(input cell_t c);
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			cells_if.valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		push_cell(c);
	endtask

	// One edge first so the monitor has taken the last beat
	task automatic quiet_until_drained();
		cells_if.valid <= 1'b0;
		@(posedge clk);
		while (shells.owed_means.size() != 0) @(posedge clk);
	endtask

	// A tidy shell shares its radii across cells; otherwise each cell is random
	task automatic run_shell(input int n, input bit tidy);
		logic [DATA_W-1:0] ro, ri, t;
		ro = pick_q30();
		ri = pick_q30();
		if (tidy && ri > ro) begin
			t = ro;
			ro = ri;
			ri = t;
		end
		for (int k = 0; k < n; k++)
			offer_cell(make_cell(pick_density(), pick_q30(), pick_phi(),
				tidy ? ro : pick_q30(), tidy ? ri : pick_q30(), k == n - 1));
	endtask

	initial begin
		int n;
		int random_cells;
		arst_n <= 1'b0;
		cells_if.valid <= 1'b0;
		cells_if.density <= '0;
		cells_if.theta_weight <= '0;
		cells_if.phi_weight <= '0;
		cells_if.outer_radius <= '0;
		cells_if.inner_radius <= '0;
		cells_if.last_in_shell <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full-scale cell alone in its shell
		offer_cell(make_cell('1, CLAMP_MAX, '1, CLAMP_MAX, '0, 1'b1));
		// Nothing at all: empty volume
		offer_cell(make_cell('0, '0, '0, '0, '0, 1'b1));
		// Theta weight and outer radius above 2.0 get clamped
		offer_cell(make_cell($urandom, '1, $urandom, '1, 32'h4000_0000, 1'b1));
		// Both radii above 2.0 clamp to the same value: no volume
		offer_cell(make_cell($urandom, CLAMP_MAX, '1, 32'hC000_0000, '1, 1'b1));
		// Inner radius outside the outer one
		offer_cell(make_cell(32'h0001_0000, CLAMP_MAX, 32'h2000_0000,
			32'h2000_0000, 32'h3000_0000, 1'b1));
		// Radius so small its cube truncates to zero
		offer_cell(make_cell('1, CLAMP_MAX, '1, 32'h0000_0400, '0, 1'b1));
		// Zero density over a real volume
		offer_cell(make_cell('0, 32'h4000_0000, 32'h2000_0000, CLAMP_MAX,
			32'h4000_0000, 1'b1));
		// Two cells, each with one zero weight
		offer_cell(make_cell('1, '0, '1, CLAMP_MAX, '0, 1'b0));
		offer_cell(make_cell('1, CLAMP_MAX, '0, CLAMP_MAX, '0, 1'b1));
		// Empty cell followed by three graded densities
		offer_cell(make_cell('1, '0, '1, CLAMP_MAX, '0, 1'b0));
		for (int k = 1; k < 4; k++)
			offer_cell(make_cell(32'h0100_0000 * k, 32'h2000_0000, 32'h3243_F6A8,
				32'h3000_0000 + 32'h0400_0000 * k, 32'h2000_0000, k == 3));
		// Alternating bit patterns in every field
		offer_cell(make_cell(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'h2AAA_AAAA, 1'b0));
		offer_cell(make_cell(32'h5555_5555, 32'h2AAA_AAAA, 32'h5555_5555,
			32'h6AAA_AAAA, 32'h1555_5555, 1'b1));

		// Sender held steady from here through the result hold-off
		steady = 1'b1;
		offer_cell(make_cell(32'h0002_0000, CLAMP_MAX, 32'h2000_0000,
			CLAMP_MAX, 32'h4000_0000, 1'b1));

		// Result side held off while short shells keep coming, then drain
		hold_off_req = 1'b1;
		repeat (12) run_shell($urandom_range(1, 2), 1'b1);
		steady = 1'b0;
		quiet_until_drained();

		// Random shells: mostly tidy, short ones, some long ones
		random_cells = 0;
		while (random_cells < RANDOM_CELLS) begin
			steady = ($urandom_range(0, 5) == 0);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
			run_shell(n, $urandom_range(0, 4) != 0);
			random_cells += n;
			if ($urandom_range(0, 40) == 0)
				quiet_until_drained();
		end

		quiet_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shells.mismatches == 0 && shells.owed_means.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/svwm_pkg.sv
src/svwm_in_if.sv
src/svwm_out_if.sv
src/svwm_seq.sv
src/svwm_dp.sv
src/shell_volume_weighted_mean_unit.sv
dv/tb.sv
